FILE: hw/rtl/f2d_pkg.sv
// Package for the fp32 to dlfloat16 converter: status codes and result struct.
// No dependencies.
`timescale 1ns / 1ps
package f2d_pkg;
    typedef enum logic [1:0] {
        ST_FINE      = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] half_bits;
        t_status     status;
    } t_result;

    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
    localparam logic [14:0] SAT_CODE     = 15'h7FFF;
endpackage

FILE: hw/rtl/f2d_core.sv
// Combinational conversion of one binary32 word into a dlfloat16 result.
// Depends on f2d_pkg.
`timescale 1ns / 1ps
module f2d_core (
    input  logic             i_full,
    input  logic [31:0]      i_word,
    output f2d_pkg::t_result o_res
);
    logic        sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [24:0] m_raw;
    logic [23:0] m;
    logic [8:0]  e;
    logic [8:0]  e_adj;
    logic [8:0]  frac_hi;

    assign sgn  = i_word[31];
    assign bexp = i_word[30:23];
    assign frac = i_word[22:0];

    // Round half away from zero at bit 13, then renormalize on carry.
    always_comb begin
        m_raw   = {2'b01, frac} + 25'h0002000;
        e       = {1'b0, bexp} - 9'd96;
        m       = m_raw[24] ? m_raw[24:1] : m_raw[23:0];
        e_adj   = m_raw[24] ? e + 9'd1 : e;
        frac_hi = m[22:14];
    end

    // Classify and pick the output code.
    always_comb begin
        o_res.half_bits = {sgn, 15'd0};
        o_res.status    = f2d_pkg::ST_FINE;
        if (bexp == f2d_pkg::EXP_ALL_ONES) begin
            o_res.half_bits = {sgn, f2d_pkg::SAT_CODE};
            o_res.status = (i_full && frac != 23'd0) ? f2d_pkg::ST_INVALID
                                                     : f2d_pkg::ST_OVERFLOW;
        end else if (bexp == 8'd0) begin
            o_res.status = (i_full && frac != 23'd0) ? f2d_pkg::ST_UNDERFLOW
                                                     : f2d_pkg::ST_FINE;
        end else if (bexp < 8'd96) begin
            o_res.status = i_full ? f2d_pkg::ST_UNDERFLOW : f2d_pkg::ST_FINE;
        end else if (e_adj == 9'd0 && m[22:13] == 10'b0000000010) begin
            o_res.half_bits = {sgn, 15'd1};
            o_res.status = i_full ? f2d_pkg::ST_UNDERFLOW : f2d_pkg::ST_FINE;
        end else if (e_adj == 9'd0 && frac_hi == 9'd0) begin
            o_res.status = i_full ? f2d_pkg::ST_UNDERFLOW : f2d_pkg::ST_FINE;
        end else if ((e_adj == 9'd63 && frac_hi == 9'h1FF) || e_adj >= 9'd64) begin
            o_res.half_bits = {sgn, f2d_pkg::SAT_CODE};
            o_res.status = f2d_pkg::ST_OVERFLOW;
        end else begin
            o_res.half_bits = {sgn, e_adj[5:0], frac_hi};
        end
    end
endmodule

FILE: hw/rtl/fp32_to_dlfloat16_convert.sv
// Top level of the fp32 to dlfloat16 converter. Depends on f2d_pkg, f2d_core.
// o_done follows start through the input register and the result register.
// Throughput: one beat per cycle; busy is always low.
// Reset: synchronous active-low i_rst_n clears valid flags and sets full-flag mode.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module fp32_to_dlfloat16_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic [31:0] i_single_bits,
    output logic        o_done,
    output logic [15:0] o_half_bits,
    output logic [1:0]  o_status
);
    logic             r_full;
    logic             r_in_vld;
    logic [31:0]      r_word;
    logic             r_out_vld;
    f2d_pkg::t_result r_res;
    f2d_pkg::t_result n_res;

    assign busy = 1'b0;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full    <= 1'b1;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_full <= i_cfg_wdata;
            r_in_vld  <= start;
            r_out_vld <= r_in_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_word <= i_single_bits;
        r_res  <= n_res;
    end

    f2d_core u_core (
        .i_full (r_full),
        .i_word (r_word),
        .o_res  (n_res)
    );

    assign o_done      = r_out_vld;
    assign o_half_bits = r_res.half_bits;
    assign o_status    = r_res.status;
endmodule
